// ----- hdl/windowed_row_average_decimator_defines.svh -----
// Assertion helpers used by the checker file.
`ifndef WINDOWED_ROW_AVERAGE_DECIMATOR_DEFINES_SVH
`define WINDOWED_ROW_AVERAGE_DECIMATOR_DEFINES_SVH

// Same-cycle implication, gated by reset.
`define WRAD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("wrad: assertion failed");

// Next-cycle implication, gated by reset.
`define WRAD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("wrad: assertion failed");

`endif

// ----- hdl/wrad_pkg.sv -----
package wrad_pkg;

    localparam int SAMPLE_W   = 32;
    localparam int DELTA_W    = SAMPLE_W + 1;
    localparam int ROWS_W     = 16;
    localparam int DVS_W      = ROWS_W + 1;
    localparam int COL_W      = 4;
    localparam int OP_W       = 2;
    localparam int CFG_COLS_W = 5;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 1;
    localparam int DIV_CNT_W  = $clog2(DELTA_W + 1);
    localparam int UPC_W      = 4;

    localparam logic [ROWS_W-1:0]     WINDOW_ROWS_RST    = ROWS_W'(4);
    localparam logic [CFG_COLS_W-1:0] COLUMNS_IN_USE_RST = CFG_COLS_W'(16);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_ROWS    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS_IN_USE = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_VALUE   = 2'd0,
        OP_ROW_END = 2'd1,
        OP_PASS    = 2'd2
    } t_op;

    typedef enum logic {
        KIND_MEAN = 1'b0,
        KIND_MARK = 1'b1
    } t_kind;

    typedef struct packed {
        logic [OP_W-1:0]            op;
        logic [COL_W-1:0]           column;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic                       kind;
        logic [COL_W-1:0]           column_res;
        logic signed [SAMPLE_W-1:0] mean_value;
        logic                       last;
    } t_out_item;

    // Microcode
    typedef logic [UPC_W-1:0] t_upc;

    localparam t_upc U_FETCH    = 4'd0;
    localparam t_upc U_RD_COL   = 4'd1;
    localparam t_upc U_LOAD     = 4'd2;
    localparam t_upc U_DIV      = 4'd3;
    localparam t_upc U_WRITE    = 4'd4;
    localparam t_upc U_ROWS     = 4'd5;
    localparam t_upc U_EMIT_RD  = 4'd6;
    localparam t_upc U_EMIT_OUT = 4'd7;
    localparam t_upc U_CLEAR    = 4'd8;
    localparam t_upc U_MARK     = 4'd9;

    typedef enum logic [2:0] {
        C_NEXT          = 3'd0,
        C_JUMP          = 3'd1,
        C_DISPATCH      = 3'd2,
        C_SKIP_INACTIVE = 3'd3,
        C_SKIP_NO_EMIT  = 3'd4,
        C_SKIP_NO_COLS  = 3'd5,
        C_LOOP_MORE     = 3'd6,
        C_LOOP_DIV      = 3'd7
    } t_ucond;

    typedef struct packed {
        t_ucond cond;
        t_upc   target;
        logic   in_ready;
        logic   wait_out;
        logic   rd_col;
        logic   rd_k;
        logic   load_div;
        logic   div_step;
        logic   wr_mean;
        logic   rows_inc;
        logic   k_clear;
        logic   k_inc;
        logic   out_mean;
        logic   out_mark;
        logic   clear_all;
    } t_uword;

    function automatic t_uword ucode_rom(input t_upc upc);
        t_uword w;
        w        = '0;
        w.cond   = C_JUMP;
        w.target = U_FETCH;
        case (upc)
            U_FETCH: begin
                w.cond     = C_DISPATCH;
                w.in_ready = 1'b1;
            end
            U_RD_COL: begin
                w.cond   = C_SKIP_INACTIVE;
                w.rd_col = 1'b1;
            end
            U_LOAD: begin
                w.cond     = C_NEXT;
                w.load_div = 1'b1;
            end
            U_DIV: begin
                w.cond     = C_LOOP_DIV;
                w.target   = U_DIV;
                w.div_step = 1'b1;
            end
            U_WRITE: begin
                w.wr_mean = 1'b1;
            end
            U_ROWS: begin
                w.cond     = C_SKIP_NO_EMIT;
                w.rows_inc = 1'b1;
                w.k_clear  = 1'b1;
            end
            U_EMIT_RD: begin
                w.cond   = C_SKIP_NO_COLS;
                w.target = U_CLEAR;
                w.rd_k   = 1'b1;
            end
            U_EMIT_OUT: begin
                w.cond     = C_LOOP_MORE;
                w.target   = U_EMIT_RD;
                w.wait_out = 1'b1;
                w.out_mean = 1'b1;
                w.k_inc    = 1'b1;
            end
            U_CLEAR: begin
                w.clear_all = 1'b1;
            end
            U_MARK: begin
                w.wait_out = 1'b1;
                w.out_mark = 1'b1;
            end
            default: begin
                w.cond = C_JUMP;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- hdl/windowed_row_average_decimator.sv -----
// Column value: read the column mean, load the divider, divide, write the new mean back;
// an inactive column is dropped after the read. The restoring divider retires one quotient
// bit per cycle. End of row: count the row; a closing window emits each active column mean,
// held by output stalls, then clears the store. Results, markers too, leave a registered slot.
// Reset (i_rst_n low, synchronous): window_rows 4, columns_in_use 16, row count 0, all
// column means read as zero, output empty, sequencer back at fetch.
module windowed_row_average_decimator #(
    parameter int MAX_COLUMNS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [wrad_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [wrad_pkg::CFG_W-1:0]          i_cfg_data,
    // input items
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  wrad_pkg::t_in_item                  i_in_item,
    // result items
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output wrad_pkg::t_out_item                 o_out_item
);
    import wrad_pkg::*;

    // Address into the mean store, column count and comparison widths.
    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int NW = $clog2(MAX_COLUMNS + 1);
    localparam int CW = (NW > CFG_COLS_W) ? NW : CFG_COLS_W;
    localparam int IW = (NW > COL_W) ? NW : COL_W;

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [ROWS_W-1:0]     r_window_rows;
    logic [CFG_COLS_W-1:0] r_columns_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_rows    <= WINDOW_ROWS_RST;
            r_columns_in_use <= COLUMNS_IN_USE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WINDOW_ROWS:    r_window_rows    <= i_cfg_data[ROWS_W-1:0];
                REG_COLUMNS_IN_USE: r_columns_in_use <= i_cfg_data[CFG_COLS_W-1:0];
                default: ;
            endcase
        end
    end

    // Active columns: columns_in_use clamped to MAX_COLUMNS.
    logic [CW-1:0] w_cols_cfg;
    logic [NW-1:0] w_active;
    assign w_cols_cfg = CW'(r_columns_in_use);
    assign w_active   = (w_cols_cfg > CW'(MAX_COLUMNS)) ? NW'(MAX_COLUMNS) : NW'(w_cols_cfg);

    // ---------------------------------------------------------------
    // Sequencer: step counter plus control ROM
    // ---------------------------------------------------------------
    t_upc   r_upc, n_upc;
    t_uword w_uw;
    logic   w_slot_free;
    logic   w_stall;

    assign w_uw        = ucode_rom(r_upc);
    assign w_slot_free = !o_out_valid || i_out_ready;
    // Output steps wait here until the result slot drains.
    assign w_stall     = w_uw.wait_out && !w_slot_free;
    assign o_in_ready  = w_uw.in_ready;

    logic w_in_xfer;
    assign w_in_xfer = i_in_valid && w_uw.in_ready;

    // Captured item payload
    logic [COL_W-1:0]    r_col;
    logic [SAMPLE_W-1:0] r_sample;

    // Row count and emit loop index
    logic [ROWS_W-1:0] r_rows;
    logic [ROWS_W-1:0] w_rows_inc;
    logic              w_emit;
    logic [NW-1:0]     r_k;
    logic              w_more;
    logic              w_inactive;

    assign w_rows_inc = r_rows + 1'b1;
    // window_rows of zero behaves as one: the compare never holds, so every row emits.
    assign w_emit     = !(w_rows_inc < r_window_rows);
    assign w_more     = (r_k + 1'b1) < w_active;
    assign w_inactive = IW'(r_col) >= IW'(w_active);

    // Divider state
    logic [DIV_CNT_W-1:0] r_div_cnt;

    always_comb begin
        n_upc = t_upc'(r_upc + 1'b1);
        case (w_uw.cond)
            C_NEXT:          n_upc = t_upc'(r_upc + 1'b1);
            C_JUMP:          n_upc = w_uw.target;
            C_DISPATCH: begin
                if (!i_in_valid) begin
                    n_upc = r_upc;
                end else begin
                    case (i_in_item.op)
                        OP_VALUE:   n_upc = U_RD_COL;
                        OP_ROW_END: n_upc = U_ROWS;
                        OP_PASS:    n_upc = U_MARK;
                        default:    n_upc = U_FETCH; // unused op: dropped
                    endcase
                end
            end
            C_SKIP_INACTIVE: if (w_inactive) n_upc = w_uw.target;
            C_SKIP_NO_EMIT:  if (!w_emit) n_upc = w_uw.target;
            C_SKIP_NO_COLS:  if (w_active == '0) n_upc = w_uw.target;
            C_LOOP_MORE:     if (w_more) n_upc = w_uw.target;
            C_LOOP_DIV:      if (r_div_cnt != DIV_CNT_W'(1)) n_upc = w_uw.target;
            default:         n_upc = U_FETCH;
        endcase
        if (w_stall) begin
            n_upc = r_upc;
        end
    end

    // ---------------------------------------------------------------
    // Mean store: memory plus per-entry valid bits (invalid reads as zero)
    // ---------------------------------------------------------------
    logic [SAMPLE_W-1:0]    r_means_mem [MAX_COLUMNS];
    logic [MAX_COLUMNS-1:0] r_vld;
    logic [SAMPLE_W-1:0]    r_rd_data;
    logic                   r_rd_vld;
    logic [AW-1:0]          w_rd_addr;
    logic [AW-1:0]          w_wr_addr;
    logic [SAMPLE_W-1:0]    w_mean;
    logic [SAMPLE_W-1:0]    w_new_mean;

    assign w_rd_addr = w_uw.rd_k ? AW'(r_k) : AW'(r_col);
    assign w_wr_addr = AW'(r_col);
    assign w_mean    = r_rd_vld ? r_rd_data : '0;

    always_ff @(posedge i_clk) begin
        if (w_uw.rd_col || w_uw.rd_k) begin
            r_rd_data <= r_means_mem[w_rd_addr];
            r_rd_vld  <= r_vld[w_rd_addr];
        end
        if (w_uw.wr_mean) begin
            r_means_mem[w_wr_addr] <= w_new_mean;
        end
    end

    // ---------------------------------------------------------------
    // Datapath: delta, restoring divider by (rows + 1), mean update
    // ---------------------------------------------------------------
    logic signed [DELTA_W-1:0] w_delta;
    logic [DELTA_W-1:0]        r_quo;
    logic [DVS_W-1:0]          r_rem;
    logic [DVS_W-1:0]          r_dvs;
    logic                      r_neg;
    logic [DVS_W:0]            w_trial;
    logic                      w_qbit;
    logic [DELTA_W-1:0]        w_sum;

    assign w_delta = $signed({r_sample[SAMPLE_W-1], r_sample})
                   - $signed({w_mean[SAMPLE_W-1], w_mean});
    assign w_trial = {r_rem, r_quo[DELTA_W-1]};
    assign w_qbit  = w_trial >= {1'b0, r_dvs};
    // Quotient sign follows delta; the divisor is always positive.
    assign w_sum   = r_neg ? ({w_mean[SAMPLE_W-1], w_mean} - r_quo)
                           : ({w_mean[SAMPLE_W-1], w_mean} + r_quo);
    // Result lies between old mean and sample, so it fits the sample width.
    assign w_new_mean = w_sum[SAMPLE_W-1:0];

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_col    <= i_in_item.column;
            r_sample <= i_in_item.sample;
        end
        if (w_uw.load_div) begin
            r_neg <= w_delta[DELTA_W-1];
            r_quo <= w_delta[DELTA_W-1] ? DELTA_W'(-w_delta) : DELTA_W'(w_delta);
            r_rem <= '0;
            r_dvs <= {1'b0, r_rows} + 1'b1;
        end else if (w_uw.div_step) begin
            r_quo <= {r_quo[DELTA_W-2:0], w_qbit};
            r_rem <= w_qbit ? DVS_W'(w_trial - {1'b0, r_dvs}) : DVS_W'(w_trial);
        end
    end

    // ---------------------------------------------------------------
    // Output slot
    // ---------------------------------------------------------------
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      w_load_mean;
    logic      w_load_mark;

    assign w_load_mean = w_uw.out_mean && !w_stall;
    assign w_load_mark = w_uw.out_mark && !w_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_ff @(posedge i_clk) begin
        if (w_load_mean) begin
            r_out_item.kind       <= KIND_MEAN;
            r_out_item.column_res <= COL_W'(r_k);
            r_out_item.mean_value <= w_mean;
            r_out_item.last       <= (r_k + 1'b1) == w_active;
        end else if (w_load_mark) begin
            r_out_item.kind       <= KIND_MARK;
            r_out_item.column_res <= '0;
            r_out_item.mean_value <= '0;
            r_out_item.last       <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= U_FETCH;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
            r_rows      <= '0;
            r_k         <= '0;
            r_div_cnt   <= '0;
        end else begin
            r_upc <= n_upc;

            if (w_load_mean || w_load_mark) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (w_uw.clear_all) begin
                r_vld  <= '0;
                r_rows <= '0;
            end else begin
                if (w_uw.wr_mean) begin
                    r_vld[w_wr_addr] <= 1'b1;
                end
                if (w_uw.rows_inc) begin
                    r_rows <= w_rows_inc;
                end
            end

            if (w_uw.k_clear) begin
                r_k <= '0;
            end else if (w_uw.k_inc && !w_stall) begin
                r_k <= r_k + 1'b1;
            end

            if (w_uw.load_div) begin
                r_div_cnt <= DIV_CNT_W'(DELTA_W);
            end else if (w_uw.div_step) begin
                r_div_cnt <= r_div_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- hdl/wrad_checker.sv -----
`include "windowed_row_average_decimator_defines.svh"

module wrad_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_cfg_we,
    input logic [wrad_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input logic [wrad_pkg::CFG_W-1:0]          i_cfg_data,
    input logic                                i_in_valid,
    input logic                                o_in_ready,
    input wrad_pkg::t_in_item                  i_in_item,
    input logic                                o_out_valid,
    input logic                                i_out_ready,
    input wrad_pkg::t_out_item                 o_out_item
);
    import wrad_pkg::*;

    logic w_cfg_seen;
    assign w_cfg_seen = i_cfg_we && (i_cfg_idx == REG_WINDOW_ROWS || i_cfg_data != '0);

    // Stalled result holds.
    `WRAD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item))

    // Marker results carry fixed fields.
    `WRAD_ASSERT_IMPL(a_mark_shape, i_clk, i_rst_n, o_out_valid && o_out_item.kind == KIND_MARK, o_out_item.last && o_out_item.column_res == '0 && o_out_item.mean_value == '0)

    // A meaningful item occupies the block: no transfer in the next cycle.
    `WRAD_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, i_in_valid && o_in_ready && (i_in_item.op == OP_VALUE || i_in_item.op == OP_ROW_END || i_in_item.op == OP_PASS), !o_in_ready)

    // Reset empties the output slot.
    `WRAD_ASSERT_NEXT(a_reset_empty, i_clk, 1'b1, !i_rst_n || (w_cfg_seen && 1'b0), !o_out_valid)

endmodule

bind windowed_row_average_decimator wrad_checker u_wrad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_cfg_we    (i_cfg_we),
    .i_cfg_idx   (i_cfg_idx),
    .i_cfg_data  (i_cfg_data),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);

// ----- verif/windowed_row_average_decimator_tb.sv -----
module windowed_row_average_decimator_tb;
    import wrad_pkg::*;

    localparam int MAX_COLS      = 16;
    localparam int ITEM_GOAL     = 270;
    localparam int SETTLE_CYCLES = 48;   // longest silent item is a value
    localparam int HOLD_CYCLES   = 400;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7fff_ffff;
    localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_W-1:0]      i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_item  = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_item;

    windowed_row_average_decimator #(
        .MAX_COLUMNS(MAX_COLS)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_item (o_out_item)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // Predictor state: per-column running means, rows in the window, registers
    logic signed [SAMPLE_W-1:0] avg_acc [MAX_COLS] = '{default: '0};
    logic [ROWS_W-1:0]          rows_seen = '0;
    logic [ROWS_W-1:0]          win_cfg   = WINDOW_ROWS_RST;
    logic [CFG_COLS_W-1:0]      cols_cfg  = COLUMNS_IN_USE_RST;
    t_out_item                  avg_due[$];

    // Tag riding along with the item being offered: typed rows carry their result
    bit        in_typed = 1'b0;
    t_out_item in_want  = '0;

    int  n_bad      = 0;
    int  n_counted  = 0;
    bit  in_calm    = 1'b0;
    bit  out_calm   = 1'b0;
    int  hold_asked = 0;
    int  hold_given = 0;
    int  hold_left  = 0;

    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_data;
        t_in_item             item;
        bit                   typed;
        t_out_item            want;
    } t_script_row;

    t_script_row script[$];

    function automatic int active_cols();
        return (cols_cfg > MAX_COLS) ? MAX_COLS : int'(cols_cfg);
    endfunction

    function automatic t_in_item mk_item(input logic [OP_W-1:0] op,
                                         input logic [COL_W-1:0] col,
                                         input logic signed [SAMPLE_W-1:0] s);
        t_in_item it;
        it.op     = op;
        it.column = col;
        it.sample = s;
        return it;
    endfunction

    function automatic t_script_row row_of(input t_in_item it, input bit typed,
                                           input t_out_item w);
        t_script_row r;
        r.is_cfg   = 1'b0;
        r.reg_idx  = '0;
        r.reg_data = '0;
        r.item     = it;
        r.typed    = typed;
        r.want     = w;
        return r;
    endfunction

    function automatic t_script_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                            input logic [CFG_W-1:0] data);
        t_script_row r;
        r          = row_of('0, 1'b0, '0);
        r.is_cfg   = 1'b1;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return S_MAX;
            1: return S_MIN;
            2, 3: return SAMPLE_W'($urandom_range(0, 200)) - 32'sd100;
            default: return $urandom;
        endcase
    endfunction

    // Advance the column means for one accepted item and queue what it emits.
    // A typed row queues its hand-written result instead of the computed one.
    task automatic fold_item(input t_in_item it, input bit typed, input t_out_item w);
        longint    delta;
        longint    quo;
        int        n;
        t_out_item r;
        case (it.op)
            OP_VALUE: begin
                if (it.column < active_cols()) begin
                    delta = longint'($signed(it.sample)) - longint'(avg_acc[it.column]);
                    quo   = delta / (longint'(rows_seen) + 1);   // truncates toward zero
                    avg_acc[it.column] = SAMPLE_W'(longint'(avg_acc[it.column]) + quo);
                end
            end
            OP_ROW_END: begin
                rows_seen = rows_seen + 1'b1;
                if (rows_seen >= win_cfg) begin
                    n = active_cols();
                    for (int k = 0; k < n; k++) begin
                        r.kind       = KIND_MEAN;
                        r.column_res = COL_W'(k);
                        r.mean_value = avg_acc[k];
                        r.last       = (k == n - 1);
                        if (!typed) avg_due.push_back(r);
                    end
                    for (int k = 0; k < MAX_COLS; k++) avg_acc[k] = '0;
                    rows_seen = '0;
                end
            end
            OP_PASS: begin
                r      = '0;
                r.kind = KIND_MARK;
                r.last = 1'b1;
                if (!typed) avg_due.push_back(r);
            end
            default: ;
        endcase
        if (typed) avg_due.push_back(w);
    endtask

    task automatic check_field(input string name, input logic signed [63:0] exp_v,
                               input logic signed [63:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            n_bad++;
        end
    endtask

    // Monitor: register writes, input transfers into the predictor, results checked
    always @(posedge i_clk) begin : watch
        t_out_item want;
        if (i_rst_n) begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_WINDOW_ROWS) win_cfg = i_cfg_data;
                else cols_cfg = i_cfg_data[CFG_COLS_W-1:0];
            end
            if (i_in_valid && o_in_ready) fold_item(i_in_item, in_typed, in_want);
            if (o_out_valid && i_out_ready) begin
                if (avg_due.size() == 0) begin
                    $error("unexpected result: kind %0d column %0d mean %0d",
                           o_out_item.kind, o_out_item.column_res, o_out_item.mean_value);
                    n_bad++;
                end else begin
                    want = avg_due.pop_front();
                    check_field("kind", want.kind, o_out_item.kind);
                    check_field("column_res", want.column_res, o_out_item.column_res);
                    check_field("mean_value", want.mean_value, o_out_item.mean_value);
                    check_field("last", want.last, o_out_item.last);
                end
            end
        end
    end

    // Receiver: random stalls, a calm stretch, and one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_given != hold_asked) begin
            hold_given = hold_asked;
            hold_left  = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= out_calm || ($urandom_range(0, 99) >= 15);
        end
    end

    task automatic offer(input t_in_item it, input bit typed, input t_out_item w);
        if (!in_calm && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        in_typed   <= typed;
        in_want    <= w;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
    endtask

    // Stop offering, wait out every owed result, then let a slow item finish
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (avg_due.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // One data row: mostly well formed, with skipped or repeated columns,
    // stray markers, unused op codes and values for inactive columns
    task automatic issue_row(input int act);
        if ($urandom_range(0, 11) == 0) begin
            offer(mk_item(OP_PASS, COL_W'($urandom), pick_sample()), 1'b0, '0);
            n_counted++;
        end
        if ($urandom_range(0, 19) == 0)
            offer(mk_item(OP_UNUSED, COL_W'($urandom), pick_sample()), 1'b0, '0);
        for (int c = 0; c < act; c++) begin
            if ($urandom_range(0, 9) != 0) begin
                offer(mk_item(OP_VALUE, COL_W'(c), pick_sample()), 1'b0, '0);
                n_counted++;
            end
            if ($urandom_range(0, 19) == 0) begin
                offer(mk_item(OP_VALUE, COL_W'(c), pick_sample()), 1'b0, '0);
                n_counted++;
            end
        end
        if (act < MAX_COLS && $urandom_range(0, 4) == 0)
            offer(mk_item(OP_VALUE, COL_W'($urandom_range(act, MAX_COLS - 1)), pick_sample()),
                  1'b0, '0);
        offer(mk_item(OP_ROW_END, COL_W'($urandom), pick_sample()), 1'b0, '0);
        n_counted++;
    endtask

    initial begin : run
        int               win;
        int               cols;
        int               rows;
        int               phase;
        logic [CFG_W-1:0] cols_data;

        // Reset defaults: window of 4, all 16 columns
        script.push_back(row_of(mk_item(OP_PASS, 4'd9, S_MIN), 1'b1,
                                t_out_item'{KIND_MARK, 4'd0, 32'sd0, 1'b1}));
        script.push_back(row_of(mk_item(OP_UNUSED, 4'd15, -32'sd1), 1'b0, '0));
        script.push_back(row_of(mk_item(OP_VALUE, 4'd0, S_MAX), 1'b0, '0));
        script.push_back(row_of(mk_item(OP_VALUE, 4'd15, S_MIN), 1'b0, '0));
        script.push_back(row_of(mk_item(OP_VALUE, 4'd7, -32'sd1), 1'b0, '0));
        script.push_back(row_of(mk_item(OP_VALUE, 4'd0, S_MIN), 1'b0, '0));
        script.push_back(row_of(mk_item(OP_ROW_END, 4'd0, 32'sd0), 1'b0, '0));
        script.push_back(row_of(mk_item(OP_VALUE, 4'd0, S_MAX), 1'b0, '0));
        script.push_back(row_of(mk_item(OP_ROW_END, 4'd0, 32'sd0), 1'b0, '0));
        script.push_back(row_of(mk_item(OP_ROW_END, 4'd0, 32'sd0), 1'b0, '0)); // empty row
        script.push_back(row_of(mk_item(OP_ROW_END, 4'd0, 32'sd0), 1'b0, '0)); // window closes
        // Zero window acts as one; single column
        script.push_back(cfg_row(REG_WINDOW_ROWS, 16'd0));
        script.push_back(cfg_row(REG_COLUMNS_IN_USE, 16'd1));
        script.push_back(row_of(mk_item(OP_VALUE, 4'd0, S_MAX), 1'b0, '0));
        script.push_back(row_of(mk_item(OP_ROW_END, 4'd0, 32'sd0), 1'b1,
                                t_out_item'{KIND_MEAN, 4'd0, S_MAX, 1'b1}));
        script.push_back(row_of(mk_item(OP_VALUE, 4'd1, 32'sd5), 1'b0, '0)); // inactive
        script.push_back(row_of(mk_item(OP_ROW_END, 4'd0, 32'sd0), 1'b1,
                                t_out_item'{KIND_MEAN, 4'd0, 32'sd0, 1'b1}));
        // No columns: the window closes silently
        script.push_back(cfg_row(REG_COLUMNS_IN_USE, 16'd0));
        script.push_back(row_of(mk_item(OP_VALUE, 4'd0, 32'sd77), 1'b0, '0));
        script.push_back(row_of(mk_item(OP_ROW_END, 4'd0, 32'sd0), 1'b0, '0));
        // Column count above the maximum clamps; widest window, then lowered mid-window
        script.push_back(cfg_row(REG_COLUMNS_IN_USE, 16'd31));
        script.push_back(cfg_row(REG_WINDOW_ROWS, 16'hffff));
        script.push_back(row_of(mk_item(OP_VALUE, 4'd15, S_MIN), 1'b0, '0));
        script.push_back(row_of(mk_item(OP_ROW_END, 4'd0, 32'sd0), 1'b0, '0));
        script.push_back(row_of(mk_item(OP_VALUE, 4'd15, 32'sd100), 1'b0, '0));
        script.push_back(row_of(mk_item(OP_ROW_END, 4'd0, 32'sd0), 1'b0, '0));
        script.push_back(cfg_row(REG_WINDOW_ROWS, 16'd2));
        script.push_back(row_of(mk_item(OP_ROW_END, 4'd0, 32'sd0), 1'b0, '0));

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_cfg) begin
                settle();
                cfg_write(script[i].reg_idx, script[i].reg_data);
            end else begin
                offer(script[i].item, script[i].typed, script[i].want);
                n_counted++;
            end
        end

        phase = 0;
        while (n_counted < ITEM_GOAL) begin
            settle();
            if (phase == 0) begin
                // short rows, every row emits: fills the block during the hold-off
                win  = 1;
                cols = 3;
            end else begin
                win  = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(0, 4);
                cols = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31)
                                                   : $urandom_range(1, MAX_COLS);
            end
            cols_data = CFG_W'($urandom);
            cols_data[CFG_COLS_W-1:0] = CFG_COLS_W'(cols);
            cfg_write(REG_WINDOW_ROWS, CFG_W'(win));
            cfg_write(REG_COLUMNS_IN_USE, cols_data);
            in_calm  = (phase == 1);
            out_calm = (phase == 1);
            if (phase == 0) begin
                hold_asked++;
                rows = 8;
            end else begin
                rows = ((win == 0) ? 1 : win) * $urandom_range(1, 3) + $urandom_range(0, 1);
            end
            // the last window may stay partial once the item count is reached
            for (int r = 0; r < rows && n_counted < ITEM_GOAL; r++)
                issue_row((cols > MAX_COLS) ? MAX_COLS : cols);
            phase++;
        end

        settle();
        if (avg_due.size() != 0) begin
            $error("%0d expected results never arrived", avg_due.size());
            n_bad++;
        end
        if (n_bad == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/wrad_pkg.sv
hdl/windowed_row_average_decimator.sv
hdl/wrad_checker.sv
verif/windowed_row_average_decimator_tb.sv
